// File: design/crsf_pkg.sv
`default_nettype none

package crsf_pkg;

    localparam int unsigned ChanWidth  = 11;
    localparam int unsigned PendWidth  = 7;
    localparam int unsigned CountWidth = 3;
    localparam int unsigned SlotWidth  = 4;
    localparam int unsigned MaxBytes   = 4;

    localparam logic [7:0] SyncByte = 8'hC8;
    localparam logic [7:0] LenByte  = 8'd24;
    localparam logic [7:0] TypeByte = 8'h16;
    localparam logic [7:0] CrcPoly  = 8'hD5;

    localparam logic [SlotWidth-1:0] FirstSlot = '0;
    localparam logic [SlotWidth-1:0] LastSlot  = '1;

    // CRC-8/DVB-S2 over one byte, MSB first, no reflection.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
        end
        return c;
    endfunction

    // CRC state after the type byte, the start of every frame.
    localparam logic [7:0] CrcAfterType = crc_feed(8'h00, TypeByte);

    // Bytes caused by one channel value, in wire order.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [2:0]               count;     // 1..4
        logic                     frame_end; // last byte is the CRC
    } burst_t;

endpackage

`default_nettype wire

// File: design/crsf_in_stage.sv
`default_nettype none

module crsf_in_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [crsf_pkg::ChanWidth-1:0]  s_value,
    input  wire logic                            take,
    output logic                                 item_valid,
    output logic [crsf_pkg::ChanWidth-1:0]       item_value
);

    logic                              valid_reg;
    logic [crsf_pkg::ChanWidth-1:0]    value_reg;

    // Accept when empty or when the held item leaves this cycle.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_value = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            value_reg <= s_value;
        end
    end

endmodule

`default_nettype wire

// File: design/crsf_pack.sv
`default_nettype none

module crsf_pack (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [crsf_pkg::ChanWidth-1:0]  value,
    input  wire logic                            advance,
    output crsf_pkg::burst_t                     burst
);

    logic [crsf_pkg::SlotWidth-1:0]   slot_reg,  slot_next;
    logic [crsf_pkg::PendWidth-1:0]   pend_reg,  pend_next;
    logic [crsf_pkg::CountWidth-1:0]  cnt_reg,   cnt_next;
    logic [7:0]                       crc_reg,   crc_next;

    logic                             first_slot;
    logic                             last_slot;
    logic [crsf_pkg::PendWidth-1:0]   pend_in;
    logic [crsf_pkg::CountWidth-1:0]  cnt_in;
    logic [7:0]                       crc_in;
    logic [17:0]                      acc;
    logic [4:0]                       nbits;
    logic                             two_bytes;
    logic [7:0]                       crc_one;
    logic [7:0]                       crc_two;
    logic [7:0]                       crc_out;

    always_comb begin
        first_slot = (slot_reg == crsf_pkg::FirstSlot);
        last_slot  = (slot_reg == crsf_pkg::LastSlot);

        // Restart the bit stream and CRC on the first slot.
        pend_in = first_slot ? '0 : pend_reg;
        cnt_in  = first_slot ? '0 : cnt_reg;
        crc_in  = first_slot ? crsf_pkg::CrcAfterType : crc_reg;

        acc       = {11'd0, pend_in} | ({7'd0, value} << cnt_in);
        nbits     = {2'b00, cnt_in} + 5'd11;
        two_bytes = nbits[4];

        crc_one = crsf_pkg::crc_feed(crc_in, acc[7:0]);
        crc_two = crsf_pkg::crc_feed(crc_one, acc[15:8]);
        crc_out = two_bytes ? crc_two : crc_one;

        if (two_bytes) begin
            pend_next = {5'd0, acc[17:16]};
        end else begin
            pend_next = acc[14:8];
        end
        cnt_next  = nbits[2:0];
        crc_next  = crc_out;
        slot_next = slot_reg + 1'b1;
        if (last_slot) begin
            pend_next = '0;
            cnt_next  = '0;
        end

        burst = '0;
        if (first_slot) begin
            // Header plus the single data byte that slot 0 always yields.
            burst.bytes[0] = crsf_pkg::SyncByte;
            burst.bytes[1] = crsf_pkg::LenByte;
            burst.bytes[2] = crsf_pkg::TypeByte;
            burst.bytes[3] = acc[7:0];
            burst.count    = 3'd4;
        end else begin
            burst.bytes[0] = acc[7:0];
            burst.bytes[1] = two_bytes ? acc[15:8] : crc_out;
            burst.bytes[2] = crc_out;
            burst.count    = {2'b00, two_bytes} + 3'd1 + {2'b00, last_slot};
        end
        burst.frame_end = last_slot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            pend_reg <= '0;
            cnt_reg  <= '0;
            crc_reg  <= '0;
        end else if (advance) begin
            slot_reg <= slot_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

`default_nettype wire

// File: design/crsf_out_buf.sv
`default_nettype none

module crsf_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire crsf_pkg::burst_t  burst,
    output logic                   load,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic [crsf_pkg::MaxBytes-1:0][7:0] bytes_reg;
    logic [2:0]                         cnt_reg;
    logic [1:0]                         idx_reg;
    logic                               fend_reg;
    logic                               valid_reg;

    logic last_byte;
    logic pop;
    logic room;

    assign last_byte = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign pop       = valid_reg && m_tready;
    assign room      = !valid_reg || (pop && last_byte);
    assign load      = in_valid && room;

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = last_byte;
    assign m_tuser  = fend_reg && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (pop && last_byte) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
            cnt_reg   <= burst.count;
            fend_reg  <= burst.frame_end;
        end
    end

endmodule

`default_nettype wire

// File: design/crsf_rc_channel_framer.sv
`default_nettype none

// RC channels frame builder. Feed 16 channel values (11 bits each, in
// s_tdata[10:0]) per frame; the block emits a 26-byte frame one byte per
// transaction on the m_ side: sync 0xC8, length 24, type 0x16, 22 bytes of
// channels packed LSB first, then a CRC-8 (poly 0xD5, init 0) over the type
// and payload bytes. Each input yields 1 to 4 bytes: the first channel of a
// frame brings the three header bytes with it, the last channel ends with
// the CRC. m_tlast marks the last byte caused by one input, and m_tuser
// marks the CRC byte that closes the frame. An input waits in the input
// register until the result buffer has room, is packed into it, and its
// first byte appears the cycle after; the result buffer drains one byte
// per cycle while m_tready is high and takes the next packed item on the
// edge its last byte leaves, so throughput is set by the byte-wide output.
// No reset-time sweep.
module crsf_rc_channel_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [10:0] channel_value, [15:11] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] frame_byte
    output logic             m_tlast,   // run_end
    output logic             m_tuser    // [0] frame_end
);

    logic                                item_valid;
    logic [crsf_pkg::ChanWidth-1:0]      item_value;
    logic                                load;
    crsf_pkg::burst_t                    burst;

    // Hold one channel value ahead of the packer.
    crsf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_value    (s_tdata[crsf_pkg::ChanWidth-1:0]),
        .take       (load),
        .item_valid (item_valid),
        .item_value (item_value)
    );

    // Pack the value, advance slot, bit stream and CRC when it is loaded.
    crsf_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .value   (item_value),
        .advance (load),
        .burst   (burst)
    );

    // Serialize the bytes of one input onto the output stream.
    crsf_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (item_valid),
        .burst    (burst),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Bound on the whole run; the slowest legal run is far below this.
    localparam int CycleLimit   = 200000;
    localparam int DirRows      = 20;
    localparam int RandPerPhase = 60;
    localparam int NumPhases    = 4;
    localparam int DrainCycles  = 20;

    // One byte on the wire with its two markers.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       frame_end;
    } wire_byte_t;

    // Directed row: a channel value and, where the bytes are obvious,
    // the bytes it must produce (typed_cnt == 0 means use the predictor).
    typedef struct packed {
        logic [crsf_pkg::ChanWidth-1:0] value;
        logic [2:0]                     typed_cnt;
        logic [3:0][7:0]                typed;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [10:0] channel_value, [15:11] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] frame_byte
    logic        m_tlast;         // run_end
    logic        m_tuser;         // [0] frame_end

    // Packer state mirrored by the predictor.
    logic [crsf_pkg::SlotWidth-1:0]  slot_q     = crsf_pkg::FirstSlot;
    logic [crsf_pkg::PendWidth-1:0]  carry_bits = '0;
    logic [crsf_pkg::CountWidth-1:0] carry_cnt  = '0;
    logic [7:0]                      frame_crc  = '0;

    wire_byte_t run_bytes [$];   // bytes caused by the value just accepted
    wire_byte_t wire_due  [$];   // bytes still owed by the block, oldest first

    dir_row_t dir_table [DirRows];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int cycle          = 0;

    int phase_send_pct [NumPhases] = '{0, 66, 0, 30};
    int phase_recv_pct [NumPhases] = '{0, 0, 66, 30};

    crsf_rc_channel_framer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // CRC-8 with polynomial 0xD5, MSB first, one byte at a time.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ crsf_pkg::CrcPoly) : {r[6:0], 1'b0};
        return r;
    endfunction

    // Work out the bytes that one channel value completes and advance the
    // mirrored packer state. Leaves them in run_bytes, last one flagged.
    function automatic void predict_run(input logic [crsf_pkg::ChanWidth-1:0] value);
        logic [17:0] acc;
        int          nbits;
        wire_byte_t  tail;
        run_bytes.delete();
        // Open a frame: clean bit stream, CRC seeded with the type byte.
        if (slot_q == crsf_pkg::FirstSlot) begin
            carry_bits = '0;
            carry_cnt  = '0;
            frame_crc  = crc8_step(8'h00, crsf_pkg::TypeByte);
            run_bytes.push_back('{crsf_pkg::SyncByte, 1'b0, 1'b0});
            run_bytes.push_back('{crsf_pkg::LenByte, 1'b0, 1'b0});
            run_bytes.push_back('{crsf_pkg::TypeByte, 1'b0, 1'b0});
        end
        // Append the value above the leftover bits and emit whole bytes.
        acc   = (18'(value) << carry_cnt) | 18'(carry_bits);
        nbits = int'(carry_cnt) + crsf_pkg::ChanWidth;
        while (nbits >= 8) begin
            frame_crc = crc8_step(frame_crc, acc[7:0]);
            run_bytes.push_back('{acc[7:0], 1'b0, 1'b0});
            acc   = acc >> 8;
            nbits = nbits - 8;
        end
        carry_bits = acc[crsf_pkg::PendWidth-1:0];
        carry_cnt  = crsf_pkg::CountWidth'(nbits);
        // Close the frame with the CRC; 176 bits leave nothing behind.
        if (slot_q == crsf_pkg::LastSlot) begin
            run_bytes.push_back('{frame_crc, 1'b0, 1'b1});
            carry_bits = '0;
            carry_cnt  = '0;
        end
        slot_q = slot_q + 1'b1;
        tail = run_bytes[run_bytes.size() - 1];
        tail.run_end = 1'b1;
        run_bytes[run_bytes.size() - 1] = tail;
    endfunction

    // Random channel value, weighted toward the corners of the range.
    function automatic logic [crsf_pkg::ChanWidth-1:0] rand_channel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return crsf_pkg::ChanWidth'(1) << $urandom_range(crsf_pkg::ChanWidth - 1);
            3: return ~(crsf_pkg::ChanWidth'(1) << $urandom_range(crsf_pkg::ChanWidth - 1));
            default: return crsf_pkg::ChanWidth'($urandom_range(2047));
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle, what);
    endtask

    // Offer one channel value, wait for its transaction and queue what it owes.
    // Called with no time advance after the previous transaction, so valid is
    // either refreshed or dropped in that same step.
    task automatic send_channel(input logic [crsf_pkg::ChanWidth-1:0] value,
                                input logic [2:0] typed_cnt,
                                input logic [3:0][7:0] typed);
        // Idle the sender for a random gap.
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(value);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Accepted at this edge: keep the mirrored state in step regardless.
        predict_run(value);
        if (typed_cnt != 0) begin
            run_bytes.delete();
            for (int k = 0; k < typed_cnt; k++)
                run_bytes.push_back('{typed[k], (k == typed_cnt - 1), 1'b0});
        end
        foreach (run_bytes[k]) wire_due.push_back(run_bytes[k]);
    endtask

    // Drop valid and hold off until every owed byte has arrived.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (wire_due.size() != 0) @(posedge aclk);
    endtask

    // Result side: check each byte transaction, then pick next cycle's ready.
    always @(posedge aclk) begin
        wire_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (wire_due.size() == 0) begin
                flag_mismatch($sformatf("byte %02h with nothing owed", m_tdata));
            end else begin
                want = wire_due.pop_front();
                if (m_tdata !== want.data)
                    flag_mismatch($sformatf("frame_byte %02h, want %02h", m_tdata, want.data));
                if (m_tlast !== want.run_end)
                    flag_mismatch($sformatf("run_end %b, want %b", m_tlast, want.run_end));
                if (m_tuser !== want.frame_end)
                    flag_mismatch($sformatf("frame_end %b, want %b", m_tuser, want.frame_end));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        // One full frame of corner values, then the start of the next one.
        // Typed rows: first value after reset, the byte it leaves behind,
        // and the header that reopens the second frame.
        dir_table = '{
            '{11'h7FF, 3'd4,
              {8'hFF, crsf_pkg::TypeByte, crsf_pkg::LenByte, crsf_pkg::SyncByte}},
            '{11'h000, 3'd1, {24'h0, 8'h07}},
            '{11'h555, 3'd0, 32'h0},
            '{11'h2AA, 3'd0, 32'h0},
            '{11'h001, 3'd0, 32'h0},
            '{11'h400, 3'd0, 32'h0},
            '{11'h7FE, 3'd0, 32'h0},
            '{11'h3FF, 3'd0, 32'h0},
            '{11'h0F0, 3'd0, 32'h0},
            '{11'h70F, 3'd0, 32'h0},
            '{11'h123, 3'd0, 32'h0},
            '{11'h6DC, 3'd0, 32'h0},
            '{11'h7FF, 3'd0, 32'h0},
            '{11'h7FF, 3'd0, 32'h0},
            '{11'h000, 3'd0, 32'h0},
            '{11'h7FF, 3'd0, 32'h0},
            '{11'h000, 3'd4,
              {8'h00, crsf_pkg::TypeByte, crsf_pkg::LenByte, crsf_pkg::SyncByte}},
            '{11'h7FF, 3'd0, 32'h0},
            '{11'h2AA, 3'd0, 32'h0},
            '{11'h555, 3'd0, 32'h0}
        };

        // Hold reset low, then release it.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows run with both sides always ready.
        for (int i = 0; i < DirRows; i++)
            send_channel(dir_table[i].value, dir_table[i].typed_cnt, dir_table[i].typed);
        hold_until_drained();

        // Random values under each idling mix; drain now and then mid-phase
        // so a pause lands on different frame slots, and always at the end.
        for (int p = 0; p < NumPhases; p++) begin
            send_idle_pct  = phase_send_pct[p];
            recv_stall_pct = phase_recv_pct[p];
            for (int n = 0; n < RandPerPhase; n++) begin
                if ($urandom_range(49) == 0) hold_until_drained();
                send_channel(rand_channel(), 3'd0, '0);
            end
            hold_until_drained();
        end

        // Let any stray byte show up before the verdict.
        recv_stall_pct = 0;
        repeat (DrainCycles) @(posedge aclk);
        if (mismatches == 0 && wire_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/crsf_pkg.sv
design/crsf_in_stage.sv
design/crsf_pack.sv
design/crsf_out_buf.sv
design/crsf_rc_channel_framer.sv
tb/sv/tb.sv
